[rtl/upt_pkg.sv]
// Shared request modes and result status codes for the unordered pair table.
package upt_pkg;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_LIST   = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_ADDED      = 4'd0,
		ST_EXISTS     = 4'd1,
		ST_SELF       = 4'd2,
		ST_FULL       = 4'd3,
		ST_DELETED    = 4'd4,
		ST_NOTFOUND   = 4'd5,
		ST_PRESENT    = 4'd6,
		ST_ABSENT     = 4'd7,
		ST_PARTNER    = 4'd8,
		ST_NOPARTNERS = 4'd9
	} status_t;

endpackage

[rtl/upt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module upt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, register one read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/unordered_pair_table.sv]
// Top level of the unordered pair table: request sequencer around the pair RAM.
//
// Use: present mode, id_a and id_b with start high; the request is taken at a
// clock edge where start is high and busy is low. busy stays high until the
// request has delivered all of its results.
// Results come out at most one beat per cycle, each with strobe high for
// exactly one cycle; the receiver takes every beat and cannot stall the block.
// Add, delete and query give one beat; list gives one beat per partner in
// slot order (or one no-partners beat), last marks the final beat.
// Every request sweeps all TABLE_DEPTH slots of the pair RAM, one read a
// cycle, then decides and writes back in the done state; the next request
// can be accepted at the edge that takes the final beat of the last one.
// The sweep through the single RAM read port sets the request rate.
// Pairs are stored as (smaller, larger); slot valid bits live in flops.
// Reset (arst_n low) clears every valid bit, so the table starts empty with
// no clearing pass; the RAM contents of an invalid slot are never used.
module unordered_pair_table #(
	parameter int TABLE_DEPTH = 64,
	parameter int ID_BITS     = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [ID_BITS-1:0] id_a,
	input  logic [ID_BITS-1:0] id_b,
	output logic               strobe,
	output logic [3:0]         status,
	output logic [ID_BITS-1:0] partner_id,
	output logic               last
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t               state_q;
	upt_pkg::mode_t       mode_q;
	logic [ID_BITS-1:0]   a_q;
	logic [ID_BITS-1:0]   b_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [IDX_W:0]       rd_q;
	logic                 chk_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 vld_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic                 pend_q;
	logic [ID_BITS-1:0]   pend_id_q;
	logic                 strobe_q;
	upt_pkg::status_t     status_q;
	logic [ID_BITS-1:0]   partner_q;
	logic                 last_q;

	logic                 issue;
	logic [IDX_W-1:0]     rd_idx;
	logic [2*ID_BITS-1:0] rdata;
	logic [ID_BITS-1:0]   lo_id;
	logic [ID_BITS-1:0]   hi_id;
	logic                 pair_hit;
	logic                 list_hit;
	logic [ID_BITS-1:0]   list_partner;
	logic                 add_ok;
	logic                 ram_we;
	logic [2*ID_BITS-1:0] wdata;

	// Issue one slot read per cycle during the sweep
	assign rd_idx = rd_q[IDX_W-1:0];
	assign issue  = (state_q == S_SCAN) && (rd_q < (IDX_W+1)'(TABLE_DEPTH));

	// Compare the returned slot against the request
	assign lo_id    = rdata[ID_BITS-1:0];
	assign hi_id    = rdata[2*ID_BITS-1:ID_BITS];
	assign pair_hit = vld_s1 && (((lo_id == a_q) && (hi_id == b_q)) ||
		((lo_id == b_q) && (hi_id == a_q)));
	assign list_hit = vld_s1 && ((lo_id == a_q) || (hi_id == a_q));
	assign list_partner = (lo_id == a_q) ? hi_id : lo_id;

	// Write back a new pair in sorted order
	assign add_ok = (mode_q == upt_pkg::MODE_ADD) && (a_q != b_q) && !found_q && free_found_q;
	assign ram_we = (state_q == S_DONE) && add_ok;
	assign wdata  = (a_q < b_q) ? {b_q, a_q} : {a_q, b_q};

	upt_ram #(
		.WIDTH(2*ID_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_idx_q),
		.wdata(wdata),
		.re   (issue),
		.raddr(rd_idx),
		.rdata(rdata)
	);

	// Sequence one request: accept, sweep, decide and write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= upt_pkg::MODE_ADD;
			a_q          <= '0;
			b_q          <= '0;
			valid_q      <= '0;
			rd_q         <= '0;
			chk_s1       <= 1'b0;
			idx_s1       <= '0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			hit_idx_q    <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			pend_q       <= 1'b0;
			pend_id_q    <= '0;
			strobe_q     <= 1'b0;
			status_q     <= upt_pkg::ST_ADDED;
			partner_q    <= '0;
			last_q       <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			chk_s1   <= issue;
			idx_s1   <= rd_idx;
			vld_s1   <= valid_q[rd_idx];
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q       <= upt_pkg::mode_t'(mode);
						a_q          <= id_a;
						b_q          <= id_b;
						rd_q         <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						pend_q       <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_q <= rd_q + 1'b1;
					end
					if (chk_s1) begin
						// Keep the lowest matching slot and the lowest free slot
						if (pair_hit && !found_q) begin
							found_q   <= 1'b1;
							hit_idx_q <= idx_s1;
						end
						if (!vld_s1 && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_s1;
						end
						// Hold one partner back so the final one can carry last
						if ((mode_q == upt_pkg::MODE_LIST) && list_hit) begin
							if (pend_q) begin
								strobe_q  <= 1'b1;
								status_q  <= upt_pkg::ST_PARTNER;
								partner_q <= pend_id_q;
								last_q    <= 1'b0;
							end
							pend_q    <= 1'b1;
							pend_id_q <= list_partner;
						end
						if (idx_s1 == IDX_W'(TABLE_DEPTH-1)) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					strobe_q  <= 1'b1;
					last_q    <= 1'b1;
					partner_q <= '0;
					unique case (mode_q)
						upt_pkg::MODE_ADD: begin
							priority if (a_q == b_q) begin
								status_q <= upt_pkg::ST_SELF;
							end else if (found_q) begin
								status_q <= upt_pkg::ST_EXISTS;
							end else if (!free_found_q) begin
								status_q <= upt_pkg::ST_FULL;
							end else begin
								status_q            <= upt_pkg::ST_ADDED;
								valid_q[free_idx_q] <= 1'b1;
							end
						end
						upt_pkg::MODE_DELETE: begin
							if (found_q) begin
								status_q           <= upt_pkg::ST_DELETED;
								valid_q[hit_idx_q] <= 1'b0;
							end else begin
								status_q <= upt_pkg::ST_NOTFOUND;
							end
						end
						upt_pkg::MODE_QUERY: begin
							status_q <= found_q ? upt_pkg::ST_PRESENT : upt_pkg::ST_ABSENT;
						end
						upt_pkg::MODE_LIST: begin
							// Flush the held partner, or report none
							if (pend_q) begin
								status_q  <= upt_pkg::ST_PARTNER;
								partner_q <= pend_id_q;
							end else begin
								status_q <= upt_pkg::ST_NOPARTNERS;
							end
						end
						default: begin
							status_q <= upt_pkg::ST_ABSENT;
						end
					endcase
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Drive the ports from registers
	assign busy       = (state_q != S_IDLE);
	assign strobe     = strobe_q;
	assign status     = status_q;
	assign partner_id = partner_q;
	assign last       = last_q;

endmodule
